>>> rtl/msc_pkg.sv
package msc_pkg;
	localparam int unsigned MemWordsDefault = 65536;
	localparam logic [4:0] LinkReg = 5'd31;
	localparam int unsigned LuiShift = 16;

	typedef enum logic [1:0] {
		ACT_EXEC = 2'd0,
		ACT_REG  = 2'd1,
		ACT_MEM  = 2'd2,
		ACT_NOP  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_HALT   = 2'd1,
		ST_BAD_OP = 2'd2,
		ST_BAD_FN = 2'd3
	} status_t;

	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_SLTI    = 6'd10;
	localparam logic [5:0] OP_ANDI    = 6'd12;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_SW      = 6'd43;

	localparam logic [5:0] FN_SLL     = 6'd0;
	localparam logic [5:0] FN_SRL     = 6'd2;
	localparam logic [5:0] FN_JR      = 6'd8;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_ADDU    = 6'd33;
	localparam logic [5:0] FN_SUBU    = 6'd35;
	localparam logic [5:0] FN_AND     = 6'd36;
	localparam logic [5:0] FN_OR      = 6'd37;
	localparam logic [5:0] FN_NOR     = 6'd39;
	localparam logic [5:0] FN_SLT     = 6'd42;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FETCH = 2'd1,
		PH_READ  = 2'd2,
		PH_MEM   = 2'd3
	} phase_t;
endpackage

>>> rtl/mips_subset_single_cycle_core_top.sv
// MIPS32 subset core (addu subu and or nor slt sll srl jr syscall addiu andi
// ori slti lui lw sw beq bne j jal, no delay slots). Each request returns one
// response. Preset and no-op requests respond straight from idle; an execute
// request, unless halted, goes through instruction fetch from the word memory,
// register file read, then execute (lw adds a data memory read). The register
// file and the word memory are synchronous-read memories, and each request
// finishes before the next starts its memory accesses. A response waits in an
// output register; the next request is taken once it drains.
// Register file contents are all zero after reset through per-entry valid
// bits; memory words read before written return undefined data.
module mips_subset_single_cycle_core_top #(
	parameter int unsigned MEM_WORDS = msc_pkg::MemWordsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] target_index,
	input  logic [31:0] write_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] next_pc,
	output logic [31:0] executed_count
);
	import msc_pkg::*;

	localparam int unsigned AW = $clog2(MEM_WORDS);

	logic [31:0] mem [MEM_WORDS];
	logic [31:0] rf [32];
	logic [31:0] rf_valid_q;

	phase_t      ph_q, ph_d;
	logic [31:0] pc_q;
	logic [31:0] cnt_q;
	logic        halted_q;
	logic [31:0] ins_s1;
	logic [31:0] mem_rd_q;
	logic [31:0] rfa_q, rfb_q;
	logic [4:0]  lw_rt_s2;

	logic        busy;
	logic        out_free;
	logic        take;

	logic        mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0] mem_wdata;
	logic        mem_re;

	logic        rf_we;
	logic [4:0]  rf_waddr;
	logic [31:0] rf_wdata;

	logic        resp_set;
	status_t     resp_status;
	logic [31:0] resp_pc, resp_cnt;
	logic        ov_q;
	status_t     st_q;
	logic [31:0] npc_q, ncnt_q;

	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sh;
	logic [15:0] imm;
	logic [31:0] a, b, simm, seq, jt, addr, res;
	logic        wr_en;
	logic [4:0]  wr_reg;
	logic [31:0] pc_d;
	logic        halt_d;
	logic        lw_go;

	assign out_free = !ov_q || out_ready;
	assign busy = ph_q != PH_IDLE;
	assign in_ready = !busy && out_free;
	assign take = in_valid && in_ready;

	assign op = ins_s1[31:26];
	assign rs = ins_s1[25:21];
	assign rt = ins_s1[20:16];
	assign rd = ins_s1[15:11];
	assign sh = ins_s1[10:6];
	assign fn = ins_s1[5:0];
	assign imm = ins_s1[15:0];
	assign a = rfa_q;
	assign b = rfb_q;
	assign simm = {{16{imm[15]}}, imm};
	assign seq = pc_q + 32'd4;
	assign jt = {seq[31:28], ins_s1[25:0], 2'b00};
	assign addr = a + simm;

	always_comb begin
		ph_d = ph_q;
		mem_we = 1'b0;
		mem_waddr = AW'(target_index);
		mem_wdata = write_value;
		mem_re = 1'b0;
		mem_raddr = pc_q[AW+1:2];
		rf_we = 1'b0;
		rf_waddr = target_index[4:0];
		rf_wdata = write_value;
		resp_set = 1'b0;
		resp_status = halted_q ? ST_HALT : ST_OK;
		resp_pc = pc_q;
		resp_cnt = cnt_q;
		wr_en = 1'b0;
		wr_reg = rd;
		res = '0;
		pc_d = seq;
		halt_d = 1'b0;
		lw_go = 1'b0;
		case (ph_q)
			PH_IDLE: begin
				if (take) begin
					case (action)
						ACT_EXEC: begin
							if (halted_q) begin
								resp_set = 1'b1;
							end else begin
								mem_re = 1'b1;
								ph_d = PH_FETCH;
							end
						end
						ACT_REG: begin
							rf_we = 1'b1;
							resp_set = 1'b1;
						end
						ACT_MEM: begin
							mem_we = 1'b1;
							resp_set = 1'b1;
						end
						default: resp_set = 1'b1;
					endcase
				end
			end
			PH_FETCH: ph_d = PH_READ;
			PH_READ: begin
				resp_status = ST_OK;
				case (op)
					OP_SPECIAL: begin
						case (fn)
							FN_SLL: begin wr_en = 1'b1; res = b << sh; end
							FN_SRL: begin wr_en = 1'b1; res = b >> sh; end
							FN_JR: pc_d = a;
							FN_SYSCALL: begin halt_d = 1'b1; resp_status = ST_HALT; end
							FN_ADDU: begin wr_en = 1'b1; res = a + b; end
							FN_SUBU: begin wr_en = 1'b1; res = a - b; end
							FN_AND: begin wr_en = 1'b1; res = a & b; end
							FN_OR: begin wr_en = 1'b1; res = a | b; end
							FN_NOR: begin wr_en = 1'b1; res = ~(a | b); end
							FN_SLT: begin
								wr_en = 1'b1;
								res = {31'd0, $signed(a) < $signed(b)};
							end
							default: resp_status = ST_BAD_FN;
						endcase
					end
					OP_J: pc_d = jt;
					OP_JAL: begin wr_en = 1'b1; wr_reg = LinkReg; res = seq; pc_d = jt; end
					OP_BEQ: if (a == b) pc_d = seq + {simm[29:0], 2'b00};
					OP_BNE: if (a != b) pc_d = seq + {simm[29:0], 2'b00};
					OP_ADDIU: begin wr_en = 1'b1; wr_reg = rt; res = addr; end
					OP_SLTI: begin
						wr_en = 1'b1;
						wr_reg = rt;
						res = {31'd0, $signed(a) < $signed(simm)};
					end
					OP_ANDI: begin wr_en = 1'b1; wr_reg = rt; res = {16'd0, imm}; res = a & res; end
					OP_ORI: begin wr_en = 1'b1; wr_reg = rt; res = a | {16'd0, imm}; end
					OP_LUI: begin wr_en = 1'b1; wr_reg = rt; res = {imm, 16'd0}; end
					OP_LW: lw_go = 1'b1;
					OP_SW: begin
						mem_we = 1'b1;
						mem_waddr = addr[AW+1:2];
						mem_wdata = b;
					end
					default: resp_status = ST_BAD_OP;
				endcase
				rf_we = wr_en;
				rf_waddr = wr_reg;
				rf_wdata = res;
				resp_pc = pc_d;
				resp_cnt = cnt_q + 32'd1;
				if (lw_go) begin
					mem_re = 1'b1;
					mem_raddr = addr[AW+1:2];
					ph_d = PH_MEM;
				end else begin
					resp_set = 1'b1;
					ph_d = PH_IDLE;
				end
			end
			PH_MEM: begin
				rf_we = 1'b1;
				rf_waddr = lw_rt_s2;
				rf_wdata = mem_rd_q;
				resp_set = 1'b1;
				ph_d = PH_IDLE;
			end
			default: ph_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_raddr];
		end
		if (rf_we && rf_waddr != 5'd0) begin
			rf[rf_waddr] <= rf_wdata;
		end
		if (ph_q == PH_FETCH) begin
			ins_s1 <= mem_rd_q;
		end
		if (ph_q == PH_READ) begin
			lw_rt_s2 <= rt;
		end
	end

	// register read, addressed from the fetched word and registered during PH_FETCH
	logic [4:0] ra_s, rb_s;
	assign ra_s = mem_rd_q[25:21];
	assign rb_s = mem_rd_q[20:16];
	always_ff @(posedge clk) begin
		if (ph_q == PH_FETCH) begin
			rfa_q <= rf_valid_q[ra_s] ? rf[ra_s] : 32'd0;
			rfb_q <= rf_valid_q[rb_s] ? rf[rb_s] : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			pc_q <= '0;
			cnt_q <= '0;
			halted_q <= 1'b0;
			rf_valid_q <= '0;
			ov_q <= 1'b0;
			st_q <= ST_OK;
			npc_q <= '0;
			ncnt_q <= '0;
		end else begin
			ph_q <= ph_d;
			if (rf_we && rf_waddr != 5'd0) begin
				rf_valid_q[rf_waddr] <= 1'b1;
			end
			if (ph_q == PH_READ) begin
				pc_q <= pc_d;
				cnt_q <= cnt_q + 32'd1;
				if (halt_d) begin
					halted_q <= 1'b1;
				end
			end
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end
			if (resp_set) begin
				ov_q <= 1'b1;
				st_q <= resp_status;
				npc_q <= resp_pc;
				ncnt_q <= resp_cnt;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign status = st_q;
	assign next_pc = npc_q;
	assign executed_count = ncnt_q;

`ifndef SYNTHESIS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("request taken while busy");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt cleared");
	a_fetch_seq: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_FETCH |=> ph_q == PH_READ) else $error("fetch not followed by read");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_READ |=> cnt_q == $past(cnt_q) + 32'd1) else $error("count step");
`endif
endmodule
